// ----- rtl/tms_pkg.sv -----
// Package for the telomere motif scanner: widths, base characters, base codes and
// configuration register indexes. No dependencies.

package tms_pkg;

   // Sizing of the motif window and the position counter
   localparam int MAX_MOTIF_BASES = 16;
   localparam int COUNT_WIDTH     = 32;
   localparam int WIN_W           = 2 * MAX_MOTIF_BASES;
   localparam int LEN_W           = $clog2(MAX_MOTIF_BASES + 1);
   localparam int SHIFT_W         = LEN_W + 1;

   // Score widths: running score is signed, best score never below zero
   localparam int SCORE_W     = 34;
   localparam int BEST_W      = 33;
   localparam int SCORE_EXT_W = 36;
   localparam int OUT_W       = 32;

   // Register widths
   localparam int MOTIF_W   = 32;
   localparam int MLEN_W    = 5;
   localparam int PENALTY_W = 8;
   localparam int DROP_W    = 16;
   localparam int MINSC_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // ASCII codes of the accepted bases
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_T_LO = 8'h74;

   // 2-bit base codes
   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOTIF_CODE  = 3'd0,
      CSR_MOTIF_LEN   = 3'd1,
      CSR_PENALTY     = 3'd2,
      CSR_MAX_DROP    = 3'd3,
      CSR_MIN_SCORE   = 3'd4,
      CSR_REVERSE     = 3'd5
   } csr_index_type;

endpackage

// ----- rtl/telomere_motif_scan.sv -----
// Top level of the telomere motif scanner: input register, scoring logic,
// result register and configuration registers. Depends on tms_pkg.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid req_ready req_base_byte req_last   | in
//  rsp     | rsp_valid rsp_ready rsp_found rsp_extent      | out
//          | rsp_best_score rsp_stopped_early             |
//  csr     | csr_valid csr_ready csr_index csr_data       | in
//
// One base word per cycle while the input stage does not stall: an accepted word is held in the
// input register, where the window, rotation compare and score update finish together; a
// result it causes is written to the rsp register as the word leaves the input register.
// The input stage stalls only when a base that ends a scan waits while an earlier result
// still sits in the rsp register and rsp_ready is low. csr writes are always taken.
// Synchronous active-high reset restores register defaults and clears the scan.

module telomere_motif_scan
   import tms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_base_byte,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [OUT_W-1:0]     rsp_extent,
   output logic [OUT_W-1:0]     rsp_best_score,
   output logic                 rsp_stopped_early,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam logic signed [SCORE_EXT_W-1:0] SCORE_TOP =
      {{(SCORE_EXT_W-BEST_W+1){1'b0}}, {(BEST_W-1){1'b1}}};
   localparam logic signed [SCORE_EXT_W-1:0] SCORE_BOTTOM =
      {{(SCORE_EXT_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Configuration registers
   logic [MOTIF_W-1:0]   motif_code_ff;
   logic [MLEN_W-1:0]    motif_len_ff;
   logic [PENALTY_W-1:0] penalty_ff;
   logic [DROP_W-1:0]    max_drop_ff;
   logic [MINSC_W-1:0]   min_score_ff;
   logic                 reverse_ff;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Scan state
   logic [WIN_W-1:0]          kmer_ff, kmer_in;
   logic [LEN_W-1:0]          run_ff, run_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [BEST_W-1:0]         best_ff, best_in;
   logic [COUNT_WIDTH-1:0]    best_pos_ff, best_pos_in;
   logic                      halted_ff, halted_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [OUT_W-1:0] rsp_extent_ff, rsp_extent_in;
   logic [OUT_W-1:0] rsp_best_ff, rsp_best_in;
   logic             rsp_stop_ff, rsp_stop_in;

   // Datapath nets
   logic [LEN_W-1:0]              len_eff;
   logic [SHIFT_W-1:0]            win_bits;
   logic [WIN_W-1:0]              win_mask;
   logic [WIN_W-1:0]              motif_masked;
   logic                          base_ok;
   logic [1:0]                    base_code;
   logic [1:0]                    code_dir;
   logic [WIN_W-1:0]              kmer_next;
   logic [LEN_W-1:0]              run_next;
   logic [MAX_MOTIF_BASES-1:0]    rot_match;
   logic                          hit;
   logic [COUNT_WIDTH-1:0]        count_next;
   logic [LEN_W:0]                start_pos;
   logic                          scoring;
   logic signed [SCORE_EXT_W-1:0] score_ext;
   logic signed [SCORE_EXT_W-1:0] score_step;
   logic signed [SCORE_EXT_W-1:0] score_next;
   logic signed [SCORE_EXT_W-1:0] best_ext;
   logic signed [SCORE_EXT_W-1:0] best_gap;
   logic                          new_best;
   logic                          drop;
   logic [BEST_W-1:0]             best_next;
   logic [COUNT_WIDTH-1:0]        best_pos_next;
   logic                          found;
   logic                          emit;
   logic                          advance;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_code_ff <= '0;
         motif_len_ff  <= MLEN_W'(6);
         penalty_ff    <= PENALTY_W'(1);
         max_drop_ff   <= DROP_W'(2000);
         min_score_ff  <= MINSC_W'(300);
         reverse_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MOTIF_CODE: motif_code_ff <= csr_data[MOTIF_W-1:0];
            CSR_MOTIF_LEN:  motif_len_ff  <= csr_data[MLEN_W-1:0];
            CSR_PENALTY:    penalty_ff    <= csr_data[PENALTY_W-1:0];
            CSR_MAX_DROP:   max_drop_ff   <= csr_data[DROP_W-1:0];
            CSR_MIN_SCORE:  min_score_ff  <= csr_data[MINSC_W-1:0];
            CSR_REVERSE:    reverse_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective window length and mask
   always_comb begin
      if (motif_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (motif_len_ff > MLEN_W'(MAX_MOTIF_BASES)) begin
         len_eff = LEN_W'(MAX_MOTIF_BASES);
      end else begin
         len_eff = LEN_W'(motif_len_ff);
      end
   end

   assign win_bits     = {len_eff, 1'b0};
   assign win_mask     = ~({WIN_W{1'b1}} << win_bits);
   assign motif_masked = WIN_W'(motif_code_ff) & win_mask;

   // Base decode
   always_comb begin
      base_ok   = 1'b1;
      base_code = CODE_A;
      case (in_byte_ff)
         CHAR_A_UP, CHAR_A_LO: base_code = CODE_A;
         CHAR_C_UP, CHAR_C_LO: base_code = CODE_C;
         CHAR_G_UP, CHAR_G_LO: base_code = CODE_G;
         CHAR_T_UP, CHAR_T_LO: base_code = CODE_T;
         default:              base_ok   = 1'b0;
      endcase
   end

   assign code_dir = reverse_ff ? (CODE_T - base_code) : base_code;

   // Window shift and run length
   always_comb begin
      if (base_ok) begin
         kmer_next = ((kmer_ff << 2) | WIN_W'(code_dir)) & win_mask;
         run_next  = (run_ff < len_eff) ? run_ff + LEN_W'(1) : run_ff;
      end else begin
         kmer_next = '0;
         run_next  = '0;
      end
   end

   // One comparator per rotation of the motif
   always_comb begin
      for (int i = 0; i < MAX_MOTIF_BASES; i++) begin
         logic [SHIFT_W-1:0] lsh;
         logic [SHIFT_W-1:0] rsh;
         logic [WIN_W-1:0]   rot;
         lsh = SHIFT_W'(2 * i);
         rsh = win_bits - lsh;
         rot = ((motif_masked << lsh) | (motif_masked >> rsh)) & win_mask;
         rot_match[i] = (LEN_W'(i) < len_eff) && (rot == kmer_next);
      end
   end

   assign hit = base_ok && (run_next >= len_eff) && (|rot_match);

   // Position counter and scoring start
   assign count_next = (count_ff < COUNT_MAX) ? count_ff + COUNT_WIDTH'(1) : count_ff;
   assign start_pos  = reverse_ff ? {1'b0, len_eff} : {1'b0, len_eff} + (LEN_W+1)'(1);
   assign scoring    = count_next >= COUNT_WIDTH'(start_pos);

   // Saturating score update
   assign score_ext = SCORE_EXT_W'(score_ff);

   always_comb begin
      score_step = score_ext;
      score_next = score_ext;
      if (scoring) begin
         if (hit) begin
            score_step = score_ext + SCORE_EXT_W'(1);
            score_next = (score_step > SCORE_TOP) ? SCORE_TOP : score_step;
         end else begin
            score_step = score_ext - $signed(SCORE_EXT_W'(penalty_ff));
            score_next = (score_step < SCORE_BOTTOM) ? SCORE_BOTTOM : score_step;
         end
      end
   end

   // Best tracking and x-drop test
   assign best_ext = $signed(SCORE_EXT_W'(best_ff));
   assign new_best = score_next > best_ext;
   assign best_gap = best_ext - score_next;
   assign drop     = !new_best && (best_gap > $signed(SCORE_EXT_W'(max_drop_ff)));

   assign best_next     = new_best ? BEST_W'(score_next) : best_ff;
   assign best_pos_next = new_best ? count_next : best_pos_ff;
   assign found         = best_next >= BEST_W'(min_score_ff);

   // Handshake between the input stage and the result register
   assign emit      = in_valid_ff && !halted_ff && (drop || in_last_ff);
   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_base_byte;
         in_last_ff <= req_last;
      end
   end

   // Next scan state
   always_comb begin
      kmer_in     = kmer_ff;
      run_in      = run_ff;
      count_in    = count_ff;
      score_in    = score_ff;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      halted_in   = halted_ff;
      if (advance) begin
         if (halted_ff) begin
            // skipping after an x-drop until the end of this sequence
            if (in_last_ff) begin
               kmer_in     = '0;
               run_in      = '0;
               count_in    = '0;
               score_in    = '0;
               best_in     = '0;
               best_pos_in = '0;
               halted_in   = 1'b0;
            end
         end else if (emit) begin
            kmer_in     = '0;
            run_in      = '0;
            count_in    = '0;
            score_in    = '0;
            best_in     = '0;
            best_pos_in = '0;
            halted_in   = drop && !in_last_ff;
         end else begin
            kmer_in     = kmer_next;
            run_in      = run_next;
            count_in    = count_next;
            score_in    = SCORE_W'(score_next);
            best_in     = best_next;
            best_pos_in = best_pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_ff     <= '0;
         run_ff      <= '0;
         count_ff    <= '0;
         score_ff    <= '0;
         best_ff     <= '0;
         best_pos_ff <= '0;
         halted_ff   <= 1'b0;
      end else begin
         kmer_ff     <= kmer_in;
         run_ff      <= run_in;
         count_ff    <= count_in;
         score_ff    <= score_in;
         best_ff     <= best_in;
         best_pos_ff <= best_pos_in;
         halted_ff   <= halted_in;
      end
   end

   // Result register
   always_comb begin
      rsp_found_in  = rsp_found_ff;
      rsp_extent_in = rsp_extent_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_stop_in   = rsp_stop_ff;
      if (advance && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = found;
         rsp_extent_in = found ? OUT_W'(best_pos_next) : '0;
         rsp_best_in   = OUT_W'(best_next);
         rsp_stop_in   = drop;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_extent_ff <= rsp_extent_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_stop_ff   <= rsp_stop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_extent        = rsp_extent_ff;
   assign rsp_best_score    = rsp_best_ff;
   assign rsp_stopped_early = rsp_stop_ff;

   // Checks on the scan logic
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && halted_ff) |-> !emit)
      else $error("halted scan produced a result");

   a_score_below_best: assert property (@(posedge clock) disable iff (reset)
      score_ff <= $signed({1'b0, best_ff}))
      else $error("running score above best score");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= LEN_W'(MAX_MOTIF_BASES))
      else $error("valid run beyond window size");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (count_ff == '0 && best_ff == '0))
      else $error("scan state not cleared after result");

   a_extent_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_extent_ff == '0))
      else $error("extent reported without a telomere");

endmodule

// ----- tb/telomere_motif_scan_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for telomere_motif_scan: streams base words, predicts each scan
// result in-bench and compares it field by field. Depends on tms_pkg and the RTL top level.

module telomere_motif_scan_tb;
   import tms_pkg::*;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int ITEM_TARGET    = 1000;
   localparam int LONG_STALL     = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint SCORE_TOP    = 64'sd4294967295;
   localparam longint SCORE_BOTTOM = -64'sd8589934592;

   typedef struct {
      logic [7:0] base;
      logic       last;
   } base_word_type;

   typedef struct {
      logic             found;
      logic [OUT_W-1:0] extent;
      logic [OUT_W-1:0] best_score;
      logic             stopped_early;
   } scan_result_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_type;

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_base_byte = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_found;
   logic [OUT_W-1:0]     rsp_extent;
   logic [OUT_W-1:0]     rsp_best_score;
   logic                 rsp_stopped_early;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // register copy kept by the scoring model
   logic [MOTIF_W-1:0]   cfg_motif;
   logic [MLEN_W-1:0]    cfg_len;
   logic [PENALTY_W-1:0] cfg_penalty;
   logic [DROP_W-1:0]    cfg_drop;
   logic [MINSC_W-1:0]   cfg_min;
   logic                 cfg_rev;

   // scan state of the scoring model
   logic [WIN_W-1:0]        scan_window;
   logic [LEN_W-1:0]        scan_run;
   logic [COUNT_WIDTH-1:0]  scan_count;
   logic signed [SCORE_W-1:0] scan_score;
   logic [BEST_W-1:0]       scan_best;
   logic [COUNT_WIDTH-1:0]  scan_best_pos;
   logic                    scan_halted;

   base_word_type   pending_bases[$];
   scan_result_type expected_scans[$];

   // bookkeeping
   logic           req_taken = 1'b0;
   logic           long_stall_go = 1'b0;
   int             stall_left = 0;
   int             rx_tick = 0;
   rx_pattern_type rx_mode = RX_OPEN;
   int             send_burst = 1;
   int             send_gap = 0;
   int             idle_cycles = 0;
   int             mismatch_count = 0;
   int             results_checked = 0;
   int             xdrop_results = 0;
   int             items_queued = 0;
   int             configs_used = 0;

   telomere_motif_scan uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base_byte     (req_base_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_extent        (rsp_extent),
      .rsp_best_score    (rsp_best_score),
      .rsp_stopped_early (rsp_stopped_early),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // window length actually used by the block
   function automatic int motif_span();
      int lim;
      lim = (MAX_MOTIF_BASES > 16) ? 16 : MAX_MOTIF_BASES;
      if (cfg_len == 0) return 1;
      if (int'(cfg_len) > lim) return lim;
      return int'(cfg_len);
   endfunction

   function automatic void clear_scan();
      scan_window   = '0;
      scan_run      = '0;
      scan_count    = '0;
      scan_score    = '0;
      scan_best     = '0;
      scan_best_pos = '0;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      case (csr_index_type'(idx))
         CSR_MOTIF_CODE: cfg_motif   = data[MOTIF_W-1:0];
         CSR_MOTIF_LEN:  cfg_len     = data[MLEN_W-1:0];
         CSR_PENALTY:    cfg_penalty = data[PENALTY_W-1:0];
         CSR_MAX_DROP:   cfg_drop    = data[DROP_W-1:0];
         CSR_MIN_SCORE:  cfg_min     = data[MINSC_W-1:0];
         CSR_REVERSE:    cfg_rev     = data[0];
         default: ;
      endcase
   endfunction

   // score one accepted base word; queue a scan result when the scan ends
   task automatic score_base(input logic [7:0] ch, input logic fin);
      int              len;
      int              bits;
      int              i;
      logic [63:0]     mask;
      logic [63:0]     m;
      logic [63:0]     rot;
      logic [63:0]     shifted;
      logic [1:0]      code;
      logic            is_base;
      logic            hit;
      logic            dropped;
      longint          s;
      longint          b;
      longint          start;
      scan_result_type res;
      if (scan_halted) begin
         // skipping after an x-drop; the last word only rearms the scan
         if (fin) begin
            scan_halted = 1'b0;
            clear_scan();
         end
         return;
      end
      len     = motif_span();
      bits    = 2 * len;
      mask    = (64'd1 << bits) - 64'd1;
      hit     = 1'b0;
      dropped = 1'b0;
      is_base = 1'b1;
      code    = CODE_A;
      case (ch)
         CHAR_A_UP, CHAR_A_LO: code = CODE_A;
         CHAR_C_UP, CHAR_C_LO: code = CODE_C;
         CHAR_G_UP, CHAR_G_LO: code = CODE_G;
         CHAR_T_UP, CHAR_T_LO: code = CODE_T;
         default: is_base = 1'b0;
      endcase
      // shift window and look for any motif rotation
      if (is_base) begin
         if (cfg_rev) code = 2'd3 - code;
         shifted     = (64'(scan_window) << 2) | 64'(code);
         scan_window = WIN_W'(shifted & mask);
         if (int'(scan_run) < len) scan_run = scan_run + 1'b1;
         if (int'(scan_run) >= len) begin
            m = 64'(cfg_motif) & mask;
            for (i = 0; i < len; i++) begin
               rot = ((m << (2 * i)) | (m >> (bits - 2 * i))) & mask;
               if (rot == 64'(scan_window)) hit = 1'b1;
            end
         end
      end else begin
         scan_window = '0;
         scan_run    = '0;
      end
      if (scan_count != {COUNT_WIDTH{1'b1}}) scan_count = scan_count + 1'b1;
      // score update once the start position is reached
      s     = longint'(scan_score);
      b     = longint'({31'd0, scan_best});
      start = cfg_rev ? len : len + 1;
      if (longint'({32'd0, scan_count}) >= start) begin
         if (hit) begin
            s = s + 1;
            if (s > SCORE_TOP) s = SCORE_TOP;
         end else begin
            s = s - longint'({56'd0, cfg_penalty});
            if (s < SCORE_BOTTOM) s = SCORE_BOTTOM;
         end
      end
      scan_score = SCORE_W'(s);
      // best tracking and x-drop test
      if (s > b) begin
         scan_best     = BEST_W'(s);
         scan_best_pos = scan_count;
         b             = s;
      end else if (b - s > longint'({48'd0, cfg_drop})) begin
         dropped = 1'b1;
      end
      if (!dropped && !fin) return;
      res.found         = (b >= longint'({48'd0, cfg_min}));
      res.extent        = res.found ? scan_best_pos[OUT_W-1:0] : '0;
      res.best_score    = scan_best[OUT_W-1:0];
      res.stopped_early = dropped;
      expected_scans.push_back(res);
      clear_scan();
      scan_halted = dropped && !fin;
   endtask

   // one register write on the csr channel, valid dropped afterwards
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [MOTIF_W-1:0] motif, input logic [MLEN_W-1:0] len,
                             input logic [PENALTY_W-1:0] pen, input logic [DROP_W-1:0] drop,
                             input logic [MINSC_W-1:0] min_sc, input logic rev);
      write_csr(CSR_MOTIF_CODE, CSR_DAT_W'(motif));
      write_csr(CSR_MOTIF_LEN,  CSR_DAT_W'(len));
      write_csr(CSR_PENALTY,    CSR_DAT_W'(pen));
      write_csr(CSR_MAX_DROP,   CSR_DAT_W'(drop));
      write_csr(CSR_MIN_SCORE,  CSR_DAT_W'(min_sc));
      write_csr(CSR_REVERSE,    CSR_DAT_W'(rev));
      configs_used++;
   endtask

   // wait until the block has nothing in flight for a run of quiet cycles
   task automatic drain();
      int quiet;
      quiet = 0;
      while (quiet < SETTLE_CYCLES) begin
         @(negedge clock);
         if (pending_bases.size() != 0 || req_valid || expected_scans.size() != 0)
            quiet = 0;
         else
            quiet++;
      end
   endtask

   function automatic logic [7:0] base_char(logic [1:0] code);
      logic up;
      up = 1'($urandom_range(0, 1));
      case (code)
         CODE_A:  return up ? CHAR_A_UP : CHAR_A_LO;
         CODE_C:  return up ? CHAR_C_UP : CHAR_C_LO;
         CODE_G:  return up ? CHAR_G_UP : CHAR_G_LO;
         default: return up ? CHAR_T_UP : CHAR_T_LO;
      endcase
   endfunction

   function automatic void push_word(logic [7:0] ch, logic fin);
      base_word_type w;
      w.base = ch;
      w.last = fin;
      pending_bases.push_back(w);
      items_queued++;
   endfunction

   // motif repeat from a random rotation, with a given share of corrupted bases
   function automatic void push_repeat(int n, int noise_pct);
      int         len;
      int         off;
      int         idx;
      logic [1:0] code;
      logic [7:0] ch;
      len = motif_span();
      off = $urandom_range(0, len - 1);
      for (int k = 0; k < n; k++) begin
         idx  = (off + k) % len;
         code = 2'(cfg_motif >> (2 * (len - 1 - idx)));
         if (cfg_rev) code = 2'd3 - code;
         ch = base_char(code);
         if ($urandom_range(0, 99) < noise_pct)
            ch = $urandom_range(0, 1) ? 8'($urandom) : base_char(2'($urandom));
         push_word(ch, k == n - 1);
      end
   endfunction

   // arbitrary bytes, about half of them valid bases
   function automatic void push_noise(int n);
      for (int k = 0; k < n; k++)
         push_word($urandom_range(0, 1) ? 8'($urandom) : base_char(2'($urandom)), k == n - 1);
   endfunction

   // sender: bursts of words with random gaps
   always @(negedge clock) begin
      base_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_bases.size() > 0) begin
            w = pending_bases.pop_front();
            req_valid     <= 1'b1;
            req_base_byte <= w.base;
            req_last      <= w.last;
            if (send_burst <= 1) begin
               send_burst = $urandom_range(1, 30);
               send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               send_burst--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall patterns plus one long hold-off on request
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_stall_go) begin
         long_stall_go = 1'b0;
         stall_left    = LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_tick == 0) rx_mode = rx_pattern_type'($urandom_range(0, 3));
         rx_tick = (rx_tick + 1) % 48;
         case (rx_mode)
            RX_OPEN:     rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_ready <= (rx_tick % 8) < 5;
            default:     rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: check results, track csr writes, score accepted words
   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected scan result: found=%0b extent=%0d best=%0d early=%0b",
                           rsp_found, rsp_extent, rsp_best_score, rsp_stopped_early);
            end else begin
               want = expected_scans.pop_front();
               results_checked++;
               if (want.stopped_early) xdrop_results++;
               if (rsp_found !== want.found || rsp_extent !== want.extent ||
                   rsp_best_score !== want.best_score ||
                   rsp_stopped_early !== want.stopped_early) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("scan result %0d mismatch: expected found=%0b extent=%0d %s",
                              results_checked, want.found, want.extent, "");
                     $display("   expected best=%0d early=%0b",
                              want.best_score, want.stopped_early);
                     $display("   got found=%0b extent=%0d best=%0d early=%0b",
                              rsp_found, rsp_extent, rsp_best_score, rsp_stopped_early);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         req_taken = req_valid && req_ready;
         if (req_taken) score_base(req_base_byte, req_last);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int phase_end;
      int kind;
      // model starts from the reset defaults
      cfg_motif   = '0;
      cfg_len     = 5'd6;
      cfg_penalty = 8'd1;
      cfg_drop    = 16'd2000;
      cfg_min     = 16'd300;
      cfg_rev     = 1'b0;
      clear_scan();
      scan_halted = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: each letter in both cases, byte extremes
      push_word(CHAR_A_UP, 1'b0);
      push_word(CHAR_A_LO, 1'b0);
      push_word(CHAR_C_UP, 1'b0);
      push_word(CHAR_C_LO, 1'b0);
      push_word(CHAR_G_UP, 1'b0);
      push_word(CHAR_G_LO, 1'b0);
      push_word(CHAR_T_UP, 1'b0);
      push_word(CHAR_T_LO, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b1);
      drain();

      // length zero, harshest penalty, zero drop, zero min score
      set_config('0, 5'd0, 8'hFF, 16'd0, 16'd0, 1'b0);
      // x-drop mid-scan, then skipped words up to last
      push_word(CHAR_A_UP, 1'b0);
      push_word(CHAR_C_UP, 1'b0);
      push_word(CHAR_G_LO, 1'b0);
      push_word(CHAR_T_UP, 1'b1);
      // single hit closed by last
      push_word(CHAR_A_UP, 1'b0);
      push_word(CHAR_A_LO, 1'b1);
      // x-drop on the last word
      push_word(CHAR_A_UP, 1'b0);
      push_word(CHAR_G_UP, 1'b1);
      // last before scoring starts
      push_word(CHAR_A_UP, 1'b1);
      drain();

      // oversized length in reverse mode, mode flipped in the middle of a scan
      set_config(32'hFFFF_FFFF, 5'd31, 8'd1, 16'd100, 16'd5, 1'b1);
      push_word(CHAR_A_UP, 1'b0);
      push_word(CHAR_A_LO, 1'b0);
      drain();
      write_csr(CSR_REVERSE, '0);
      push_word(CHAR_T_UP, 1'b1);
      drain();

      // random scans, one configuration per phase; each phase drains fully
      for (int ph = 0; items_queued < ITEM_TARGET; ph++) begin
         case (ph)
            0: set_config($urandom, 5'd6, 8'd1, 16'd20, 16'd10, 1'b0);
            1: set_config($urandom, 5'd16, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1);
            2: set_config(32'hFFFF_FFFF, 5'd1, 8'hFF, 16'd0, 16'd1, 1'b0);
            3: set_config('0, 5'd31, 8'd3, 16'd30, 16'd0, 1'b0);
            4: set_config($urandom, 5'd6, 8'd1, 16'd2000, 16'd300, 1'b0);
            default:
               set_config($urandom,
                          MLEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                              : $urandom_range(1, 8)),
                          PENALTY_W'(($urandom_range(0, 7) == 0) ? 255
                                                                 : $urandom_range(0, 3)),
                          DROP_W'(($urandom_range(0, 7) == 0) ? 65535
                                                              : $urandom_range(0, 50)),
                          MINSC_W'($urandom_range(0, 25)), 1'($urandom_range(0, 1)));
         endcase
         // hold the result side off while short scans keep arriving
         if (ph == 0) begin
            long_stall_go = 1'b1;
            repeat (40) push_repeat($urandom_range(1, 3), 10);
         end
         // one clean repeat long enough to reach the default min score
         if (ph == 4) push_repeat(310, 0);
         phase_end = items_queued + 90;
         while (items_queued < phase_end) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) push_repeat($urandom_range(1, 40), $urandom_range(0, 5));
            else if (kind <= 7) push_repeat($urandom_range(5, 30), 30);
            else if (kind == 8) push_noise($urandom_range(1, 20));
            else push_repeat($urandom_range(60, 120), 2);
         end
         drain();
      end

      $display("Streamed %0d base words over %0d register settings;",
               items_queued, configs_used);
      $display("%0d scan results checked, %0d of them x-drop stops.",
               results_checked, xdrop_results);
      if (mismatch_count == 0 && expected_scans.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tms_pkg.sv
rtl/telomere_motif_scan.sv
tb/telomere_motif_scan_tb.sv
